// ----- hw/rtl/fspm_pkg.sv -----
package fspm_pkg;

  localparam int PIX_W     = 8;
  localparam int SIDE_W    = 13;
  localparam int MAX_SIDE  = 4096;
  localparam int NPIX_W    = 25;            // up to MAX_SIDE*MAX_SIDE
  localparam int CNT_W     = 24;
  localparam int FNUM_W    = 16;
  localparam int SAD_W     = 32;
  localparam int SSE_W     = 40;
  localparam int PSNR_W    = 15;
  localparam int CFG_IDX_W = 4;

  // log2 unit
  localparam int X_W       = 40;            // operand width of the log unit
  localparam int POS_W     = 6;             // leading-one position 0..39
  localparam int FRAC_W    = 16;
  localparam int LOG_W     = POS_W + FRAC_W;
  localparam int MANT_W    = 32;            // Q1.31 mantissa
  localparam int SQ_W      = 2 * MANT_W;
  localparam int BITCNT_W  = 4;
  localparam int SCALE_W   = 18;
  localparam int PROD_W    = LOG_W + SCALE_W;

  localparam logic [15:0]         PEAK_SQ  = 16'd65025;
  localparam logic [SCALE_W-1:0]  DB_SCALE = 18'd197282;
  localparam logic [PSNR_W-1:0]   PSNR_MAX = 15'd32767;
  localparam logic [FNUM_W-1:0]   FNUM_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

  localparam logic [SIDE_W-1:0] WIDTH_RST  = 13'd352;
  localparam logic [SIDE_W-1:0] HEIGHT_RST = 13'd288;

  // one finished frame, handed from the accumulator to the log engine
  typedef struct packed {
    logic [FNUM_W-1:0] fnum;
    logic [SAD_W-1:0]  sad;
    logic [SSE_W-1:0]  sse;
    logic [NPIX_W-1:0] npix;
  } frame_rec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NORM,
    BK_LOG,
    BK_MUL,
    BK_DONE
  } back_state_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    if (s == '0) begin
      r = SIDE_W'(1);
    end else if (s > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/fspm_front.sv -----
module fspm_front import fspm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_ref_pixel,
  input  logic [PIX_W-1:0]  in_dec_pixel,
  output logic              push_valid,
  input  logic              push_ready,
  output frame_rec_t        push_rec
);

  logic [SIDE_W-1:0]   width_r, height_r;
  logic [SAD_W-1:0]    sad_r, sad_nxt;
  logic [SSE_W-1:0]    sse_r, sse_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [FNUM_W-1:0]   fnum_r, fnum_nxt;
  logic [PIX_W-1:0]    diff;
  logic [2*PIX_W-1:0]  diff_sq;
  logic [2*SIDE_W-1:0] npix_full;
  logic [NPIX_W-1:0]   npix;
  logic                accept, last;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;
  assign accept    = in_valid & push_ready;

  assign diff      = (in_ref_pixel > in_dec_pixel) ? in_ref_pixel - in_dec_pixel
                                                   : in_dec_pixel - in_ref_pixel;
  assign diff_sq   = diff * diff;
  assign sad_nxt   = sad_r + SAD_W'(diff);
  assign sse_nxt   = sse_r + SSE_W'(diff_sq);

  assign npix_full = clamp_side(width_r) * clamp_side(height_r);
  assign npix      = npix_full[NPIX_W-1:0];
  // frame also ends early if the size shrank below the running count
  assign last      = ({1'b0, cnt_r} + NPIX_W'(1)) >= npix;
  assign fnum_nxt  = (fnum_r == FNUM_MAX) ? FNUM_W'(1) : fnum_r + FNUM_W'(1);

  assign push_valid    = accept & last;
  assign push_rec.fnum = fnum_nxt;
  assign push_rec.sad  = sad_nxt;
  assign push_rec.sse  = sse_nxt;
  assign push_rec.npix = npix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sad_r  <= '0;
      sse_r  <= '0;
      cnt_r  <= '0;
      fnum_r <= '0;
    end else if (accept) begin
      if (last) begin
        sad_r  <= '0;
        sse_r  <= '0;
        cnt_r  <= '0;
        fnum_r <= fnum_nxt;
      end else begin
        sad_r <= sad_nxt;
        sse_r <= sse_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/fspm_queue.sv -----
module fspm_queue import fspm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  frame_rec_t push_rec,
  output logic       pop_valid,
  input  logic       pop_ready,
  output frame_rec_t pop_rec
);

  frame_rec_t  ent_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_rec    = ent_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- hw/rtl/fspm_back.sv -----
module fspm_back import fspm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  frame_rec_t        pop_rec,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FNUM_W-1:0] out_frame_number,
  output logic [SAD_W-1:0]  out_sad_total,
  output logic [SSE_W-1:0]  out_sse_total,
  output logic [PSNR_W-1:0] out_psnr_q8,
  output logic              out_psnr_infinite
);

  back_state_t state_r, state_nxt;

  logic [FNUM_W-1:0]   fnum_r;
  logic [SAD_W-1:0]    sad_r;
  logic [SSE_W-1:0]    sse_r;
  logic                inf_r;
  logic                sel_b_r;
  logic [X_W-1:0]      x_r;
  logic [POS_W-1:0]    pos_r;
  logic [SQ_W-1:0]     sq_r;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic [BITCNT_W-1:0] bit_cnt_r;
  logic [LOG_W-1:0]    la_r, lg_cur;
  logic [LOG_W-1:0]    diff_r;
  logic [PROD_W-1:0]   prod_r;
  logic [40:0]         peak_n;
  logic [MANT_W:0]     sq_top;
  logic [MANT_W-1:0]   m_nxt, m0;
  logic                frac_bit, log_last, out_load;
  logic [15:0]         psnr_full;
  logic [PSNR_W-1:0]   psnr_sat;

  logic                out_valid_r, out_inf_r;
  logic [FNUM_W-1:0]   out_fnum_r;
  logic [SAD_W-1:0]    out_sad_r;
  logic [SSE_W-1:0]    out_sse_r;
  logic [PSNR_W-1:0]   out_psnr_r;

  // one squaring step of the fraction loop
  assign sq_top   = sq_r[SQ_W-1:MANT_W-1];
  assign frac_bit = sq_top[MANT_W];
  assign m_nxt    = frac_bit ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
  assign frac_nxt = {frac_r[FRAC_W-2:0], frac_bit};
  assign lg_cur   = {pos_r, frac_nxt};
  assign log_last = (bit_cnt_r == BITCNT_W'(FRAC_W - 1));
  assign m0       = x_r[X_W-1:X_W-MANT_W];
  assign peak_n   = PEAK_SQ * pop_rec.npix;

  assign psnr_full = prod_r[PROD_W-1:PROD_W-16];
  assign psnr_sat  = inf_r ? PSNR_MAX :
                     (psnr_full > 16'(PSNR_MAX)) ? PSNR_MAX : psnr_full[PSNR_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (pop_valid) state_nxt = (pop_rec.sse == '0) ? BK_DONE : BK_NORM;
      BK_NORM: if (x_r[X_W-1]) state_nxt = BK_LOG;
      BK_LOG:  if (log_last) state_nxt = sel_b_r ? BK_MUL : BK_NORM;
      BK_MUL:  state_nxt = BK_DONE;
      BK_DONE: if (out_load) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state_r == BK_IDLE);
    out_load  = (state_r == BK_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      sel_b_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_IDLE) begin
        sel_b_r <= 1'b0;
      end else if (state_r == BK_LOG && log_last) begin
        sel_b_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        fnum_r <= pop_rec.fnum;
        sad_r  <= pop_rec.sad;
        sse_r  <= pop_rec.sse;
        inf_r  <= (pop_rec.sse == '0);
        x_r    <= peak_n[X_W-1:0];
        pos_r  <= POS_W'(X_W - 1);
      end
      BK_NORM: begin
        if (!x_r[X_W-1]) begin
          x_r   <= {x_r[X_W-2:0], 1'b0};
          pos_r <= pos_r - POS_W'(1);
        end else begin
          sq_r      <= m0 * m0;
          frac_r    <= '0;
          bit_cnt_r <= '0;
        end
      end
      BK_LOG: begin
        frac_r    <= frac_nxt;
        sq_r      <= m_nxt * m_nxt;
        bit_cnt_r <= bit_cnt_r + BITCNT_W'(1);
        if (log_last) begin
          if (!sel_b_r) begin
            la_r  <= lg_cur;
            x_r   <= sse_r;
            pos_r <= POS_W'(X_W - 1);
          end else begin
            diff_r <= (la_r > lg_cur) ? la_r - lg_cur : '0;
          end
        end
      end
      BK_MUL: prod_r <= diff_r * DB_SCALE;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fnum_r <= fnum_r;
      out_sad_r  <= sad_r;
      out_sse_r  <= sse_r;
      out_psnr_r <= psnr_sat;
      out_inf_r  <= inf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_number  = out_fnum_r;
  assign out_sad_total     = out_sad_r;
  assign out_sse_total     = out_sse_r;
  assign out_psnr_q8       = out_psnr_r;
  assign out_psnr_infinite = out_inf_r;

endmodule

// ----- hw/rtl/frame_sad_psnr_meter_core.sv -----
// Result path: a frame record goes from the front through the queue to the log engine,
//   which normalizes both log operands (s_a, s_b: normalize shifts of the two log
//   operands, at most 24 and 39); when SSE is zero the log engine is skipped.
// Throughput: one pixel pair per cycle; the two-entry frame queue stalls in_ready only
//   when frames are shorter than the log engine's per-frame time or out_ready holds low.
// Reset: rst_n synchronous, active low; clears sums, counters, queue and output valid.
module frame_sad_psnr_meter_core import fspm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_wdata,
  // pixel pairs
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_ref_pixel,
  input  logic [PIX_W-1:0]     in_dec_pixel,
  // frame results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FNUM_W-1:0]    out_frame_number,
  output logic [SAD_W-1:0]     out_sad_total,
  output logic [SSE_W-1:0]     out_sse_total,
  output logic [PSNR_W-1:0]    out_psnr_q8,
  output logic                 out_psnr_infinite
);

  // Front: accumulates |d| and d^2 per transfer, counts pixels against
  // clamp(width)*clamp(height) and pushes a frame record on the last pixel.
  frame_rec_t push_rec, pop_rec;
  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;

  fspm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ref_pixel (in_ref_pixel),
    .in_dec_pixel (in_dec_pixel),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_rec     (push_rec)
  );

  // Two frame records of slack so pixels keep streaming while PSNR is worked out.
  fspm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  // Back: one shared log2 unit (shift-by-one normalize, then 16 squarings on a
  // 32x32 multiplier, one fraction bit per cycle), run for 65025*N then SSE;
  // difference times 197282 >> 24, saturated, into the output register.
  fspm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_rec           (pop_rec),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_number  (out_frame_number),
    .out_sad_total     (out_sad_total),
    .out_sse_total     (out_sse_total),
    .out_psnr_q8       (out_psnr_q8),
    .out_psnr_infinite (out_psnr_infinite)
  );

endmodule

// ----- hw/rtl/fspm_checker.sv -----
module fspm_checker import fspm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FNUM_W-1:0] out_frame_number,
  input logic [SAD_W-1:0]  out_sad_total,
  input logic [SSE_W-1:0]  out_sse_total,
  input logic [PSNR_W-1:0] out_psnr_q8,
  input logic              out_psnr_infinite
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sse_total)
      && $stable(out_frame_number) && $stable(out_psnr_q8))
    else $error("result changed while stalled");

  // no differences at all means both sums are zero together
  a_sad_sse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_sad_total == '0) == (out_sse_total == '0)))
    else $error("sad/sse zero mismatch");

  a_inf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_psnr_infinite == (out_sse_total == '0))
      && (!out_psnr_infinite || out_psnr_q8 == PSNR_MAX))
    else $error("infinite flag inconsistent");

  a_fnum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_number != '0)
    else $error("frame number zero");

  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_sad_psnr_meter_core fspm_checker u_fspm_checker (.*);

// ----- dv/frame_sad_psnr_meter_core_tb.sv -----
`timescale 1ns / 1ps

module frame_sad_psnr_meter_core_tb;
  import fspm_pkg::*;

  // Drain allowance: covers the worst result latency after the last pixel.
  localparam int DRAIN_CYC = 120;
  localparam int LIMIT_CYC = 500_000;
  localparam int RND_ITEMS = 560;
  localparam int RND_FRAMES = 48;
  localparam int TAIL_ITEMS = 40;

  // Register index the block does not decode; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_BOGUS_IDX = '1;

  typedef struct packed {
    logic [FNUM_W-1:0] fnum;
    logic [SAD_W-1:0]  sad;
    logic [SSE_W-1:0]  sse;
    logic [PSNR_W-1:0] psnr;
    logic              inf;
  } frame_res_t;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [SIDE_W-1:0]    wdata;
    logic [PIX_W-1:0]     rp;
    logic [PIX_W-1:0]     dp;
    logic                 typed;   // res holds a hand-written expectation
    frame_res_t           res;
  } dir_row_t;

  typedef enum logic [1:0] {STY_SAME, STY_NOISE, STY_NEAR, STY_EXTREME} pix_style_t;

  localparam frame_res_t NO_RES = '0;
  localparam int DIR_ROWS = 19;

  // Directed sequence. Starts at the reset size (352x288), so the first three
  // pixels sit in a partial frame when the size shrinks to 1x1 under them:
  // the next pixel closes a frame of four. Then identical pixels (infinite
  // PSNR), full-scale differences both ways (PSNR exactly 0), a write to an
  // undecoded index, and a 2x1 size with a leftover pixel at the end.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_PIX, 4'd0,             13'd0, 8'd10,  8'd20,  1'b0, NO_RES},
    '{ROW_PIX, 4'd0,             13'd0, 8'd255, 8'd0,   1'b0, NO_RES},
    '{ROW_PIX, 4'd0,             13'd0, 8'd0,   8'd255, 1'b0, NO_RES},
    '{ROW_CFG, CFG_FRAME_WIDTH,  13'd1, 8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_CFG, CFG_FRAME_HEIGHT, 13'd0, 8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_PIX, 4'd0,             13'd0, 8'd7,   8'd7,   1'b0, NO_RES},
    '{ROW_PIX, 4'd0,             13'd0, 8'd0,   8'd0,   1'b1,
      '{16'd2, 32'd0, 40'd0, PSNR_MAX, 1'b1}},
    '{ROW_PIX, 4'd0,             13'd0, 8'd255, 8'd0,   1'b1,
      '{16'd3, 32'd255, 40'd65025, 15'd0, 1'b0}},
    '{ROW_PIX, 4'd0,             13'd0, 8'd0,   8'd255, 1'b1,
      '{16'd4, 32'd255, 40'd65025, 15'd0, 1'b0}},
    '{ROW_PIX, 4'd0,             13'd0, 8'd255, 8'd255, 1'b1,
      '{16'd5, 32'd0, 40'd0, PSNR_MAX, 1'b1}},
    '{ROW_CFG, CFG_BOGUS_IDX,    13'd2, 8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_PIX, 4'd0,             13'd0, 8'd128, 8'd127, 1'b0, NO_RES},
    '{ROW_CFG, CFG_FRAME_WIDTH,  13'd2, 8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_CFG, CFG_FRAME_HEIGHT, 13'd1, 8'd0,   8'd0,   1'b0, NO_RES},
    '{ROW_PIX, 4'd0,             13'd0, 8'd1,   8'd0,   1'b0, NO_RES},
    '{ROW_PIX, 4'd0,             13'd0, 8'd0,   8'd3,   1'b0, NO_RES},
    '{ROW_PIX, 4'd0,             13'd0, 8'd200, 8'd100, 1'b0, NO_RES},
    '{ROW_PIX, 4'd0,             13'd0, 8'd100, 8'd200, 1'b0, NO_RES},
    '{ROW_PIX, 4'd0,             13'd0, 8'd85,  8'd170, 1'b0, NO_RES}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIDE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_ref_pixel;
  logic [PIX_W-1:0]     in_dec_pixel;
  logic                 out_valid;
  logic                 out_ready;
  logic [FNUM_W-1:0]    out_frame_number;
  logic [SAD_W-1:0]     out_sad_total;
  logic [SSE_W-1:0]     out_sse_total;
  logic [PSNR_W-1:0]    out_psnr_q8;
  logic                 out_psnr_infinite;

  // Shadow copy of the block's registers and running sums.
  logic [SIDE_W-1:0] sh_width  = WIDTH_RST;
  logic [SIDE_W-1:0] sh_height = HEIGHT_RST;
  logic [SAD_W-1:0]  acc_sad   = '0;
  logic [SSE_W-1:0]  acc_sse   = '0;
  logic [NPIX_W-1:0] acc_pix   = '0;
  logic [FNUM_W-1:0] frame_no  = '0;

  frame_res_t exp_frames [$];   // frame results still owed by the block
  int frames_pred = 0;
  int errs = 0;
  int cyc = 0;
  int hold_cnt = 0;
  bit idle_on = 1'b1;           // random gaps/stalls enabled

  frame_sad_psnr_meter_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ref_pixel     (in_ref_pixel),
    .in_dec_pixel     (in_dec_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_number (out_frame_number),
    .out_sad_total    (out_sad_total),
    .out_sse_total    (out_sse_total),
    .out_psnr_q8      (out_psnr_q8),
    .out_psnr_infinite(out_psnr_infinite)
  );

  always #6 clk = ~clk;

  // Side of 0 acts as 1, anything past MAX_SIDE as MAX_SIDE.
  function automatic int eff_side(input logic [SIDE_W-1:0] s);
    return (s == '0) ? 1 : ((int'(s) > MAX_SIDE) ? MAX_SIDE : int'(s));
  endfunction

  // log2 in Q16: integer part is the leading-one position, fraction by
  // repeated squaring of the Q1.31 mantissa (truncating).
  function automatic logic [63:0] log2_fix(input logic [63:0] x);
    int p;
    logic [63:0] m;
    logic [63:0] fr;
    p = 0;
    for (int k = 1; k < 64; k++) if (x[k]) p = k;
    m = (p >= 31) ? x >> (p - 31) : x << (31 - p);
    fr = '0;
    repeat (16) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= 64'h1_0000_0000) begin
        fr[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(p) << 16) | fr;
  endfunction

  // Accumulate one pixel pair; on the frame's last pixel, produce the result
  // and clear the sums. Frame size is taken from the current registers, so a
  // size that shrinks mid-frame ends the frame at the next pixel.
  task automatic meter_predict(input logic [PIX_W-1:0] r, d, output bit done,
                               output frame_res_t res);
    logic [SSE_W-1:0]  dif;
    logic [NPIX_W-1:0] npix;
    logic [63:0]       la;
    logic [63:0]       lb;
    logic [63:0]       dd;
    dif = (r > d) ? r - d : d - r;
    npix = NPIX_W'(eff_side(sh_width) * eff_side(sh_height));
    acc_sad = acc_sad + dif[SAD_W-1:0];
    acc_sse = acc_sse + dif * dif;
    acc_pix = acc_pix + 1'b1;
    done = (acc_pix >= npix);
    res = '0;
    if (done) begin
      frame_no = (frame_no == FNUM_MAX) ? 16'd1 : frame_no + 16'd1;
      res.fnum = frame_no;
      res.sad = acc_sad;
      res.sse = acc_sse;
      if (acc_sse == '0) begin
        res.psnr = PSNR_MAX;
        res.inf = 1'b1;
      end else begin
        la = log2_fix(64'(PEAK_SQ) * 64'(npix));
        lb = log2_fix(64'(acc_sse));
        dd = (la > lb) ? ((la - lb) * 64'(DB_SCALE)) >> 24 : 64'd0;
        res.psnr = (dd > 64'(PSNR_MAX)) ? PSNR_MAX : dd[PSNR_W-1:0];
      end
      acc_sad = '0;
      acc_sse = '0;
      acc_pix = '0;
    end
  endtask

  // One pixel transfer, with an optional idle burst ahead of it.
  task automatic send_pix(input logic [PIX_W-1:0] r, d, input bit typed,
                          input frame_res_t tres);
    bit done;
    frame_res_t pres;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_ref_pixel <= r;
    in_dec_pixel <= d;
    do @(posedge clk); while (!in_ready);
    meter_predict(r, d, done, pres);
    if (done) begin
      exp_frames.push_back(typed ? tres : pres);
      frames_pred++;
    end
  endtask

  // Register write; valid is left high so back-to-back writes stream.
  // The caller drops cfg_valid after the last one.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIDE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FRAME_WIDTH) sh_width = val;
    else if (idx == CFG_FRAME_HEIGHT) sh_height = val;
  endtask

  // Quiesce before touching registers: pixel side idle, all owed results
  // out, then the full latency for a partial frame still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (exp_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic gen_pair(input pix_style_t sty, output logic [PIX_W-1:0] r, d);
    int v;
    r = PIX_W'($urandom);
    case (sty)
      STY_SAME: begin
        d = r;
      end
      STY_NEAR: begin
        v = int'(r) + int'($urandom_range(0, 6)) - 3;
        d = (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : PIX_W'(v));
      end
      STY_EXTREME: begin
        r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
        d = PIX_W'($urandom);
      end
    endcase
  endtask

  // Result checker and output-side stall generator.
  always @(posedge clk) begin : res_mon
    frame_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (exp_frames.size() == 0) begin
        $display("%0t unexpected result: frame_number %0d sad %0d sse %0d psnr %0d inf %0d",
                 $time, out_frame_number, out_sad_total, out_sse_total, out_psnr_q8,
                 out_psnr_infinite);
        errs++;
      end else begin
        e = exp_frames.pop_front();
        if (out_frame_number !== e.fnum) begin
          $display("%0t frame_number: expected %0d, got %0d", $time, e.fnum,
                   out_frame_number);
          errs++;
        end
        if (out_sad_total !== e.sad) begin
          $display("%0t sad_total: expected %0d, got %0d", $time, e.sad, out_sad_total);
          errs++;
        end
        if (out_sse_total !== e.sse) begin
          $display("%0t sse_total: expected %0d, got %0d", $time, e.sse, out_sse_total);
          errs++;
        end
        if (out_psnr_q8 !== e.psnr) begin
          $display("%0t psnr_q8: expected %0d, got %0d", $time, e.psnr, out_psnr_q8);
          errs++;
        end
        if (out_psnr_infinite !== e.inf) begin
          $display("%0t psnr_infinite: expected %0d, got %0d", $time, e.inf,
                   out_psnr_infinite);
          errs++;
        end
      end
    end
    // random stall bursts on out_ready
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      hold_cnt = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT_CYC) begin
      $display("%0t timeout with %0d results outstanding", $time, exp_frames.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int ph;
    int nfr;
    int npx;
    int extra;
    int rnd_items;
    int rnd_frames0;
    bit big;
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
    logic [PIX_W-1:0]  r;
    logic [PIX_W-1:0]  d;
    pix_style_t        sty;

    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_ref_pixel <= '0;
    in_dec_pixel <= '0;
    out_ready    <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed table ----
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        if (i == 0 || DIR_TAB[i-1].kind != ROW_CFG) settle();
        cfg_write(DIR_TAB[i].idx, DIR_TAB[i].wdata);
      end else begin
        if (i > 0 && DIR_TAB[i-1].kind == ROW_CFG) cfg_valid <= 1'b0;
        send_pix(DIR_TAB[i].rp, DIR_TAB[i].dp, DIR_TAB[i].typed, DIR_TAB[i].res);
      end
    end

    // ---- random phases ----
    // Mostly tiny frames so results are frequent and the log engine gets
    // back-pressured. Three phases set a clamped side (4096 pixels) and leave
    // a partial frame behind, which the next, smaller size picks up. Other
    // phases may also end mid-frame so the next size lands on a partial frame.
    ph = 0;
    rnd_items = 0;
    rnd_frames0 = frames_pred;
    while (rnd_items < RND_ITEMS || frames_pred - rnd_frames0 < RND_FRAMES) begin
      settle();
      big = (ph == 3 || ph == 7 || ph == 11);
      case (ph)
        3:  begin w = 13'd8191; h = 13'd0;    end
        7:  begin w = 13'd1;    h = 13'd4096; end
        11: begin w = 13'd0;    h = 13'd4097; end
        default: begin
          w = SIDE_W'($urandom_range(0, 12));
          h = SIDE_W'($urandom_range(0, 3));
        end
      endcase
      if ($urandom_range(0, 1)) begin
        cfg_write(CFG_FRAME_WIDTH, w);
        cfg_write(CFG_FRAME_HEIGHT, h);
      end else begin
        cfg_write(CFG_FRAME_HEIGHT, h);
        cfg_write(CFG_FRAME_WIDTH, w);
      end
      if ($urandom_range(0, 2) == 0)
        cfg_write(CFG_IDX_W'($urandom_range(CFG_FRAME_HEIGHT + 1, CFG_BOGUS_IDX)),
                  SIDE_W'($urandom));
      cfg_valid <= 1'b0;
      idle_on = ($urandom_range(0, 3) != 0);
      npx = eff_side(w) * eff_side(h);
      nfr = big ? 0 : $urandom_range(1, 6);
      for (int f = 0; f < nfr; f++) begin
        sty = pix_style_t'($urandom_range(0, 3));
        for (int k = 0; k < npx; k++) begin
          gen_pair(sty, r, d);
          send_pix(r, d, 1'b0, NO_RES);
          rnd_items++;
        end
      end
      if (big) begin
        extra = $urandom_range(8, 24);
      end else if ($urandom_range(0, 3) == 0) begin
        extra = $urandom_range(1, npx);
      end else begin
        extra = 0;
      end
      sty = pix_style_t'($urandom_range(0, 3));
      for (int k = 0; k < extra; k++) begin
        gen_pair(sty, r, d);
        send_pix(r, d, 1'b0, NO_RES);
        rnd_items++;
      end
      ph++;
    end

    // ---- closing run, no idling from here on ----
    // 1x1 frames back to back keep the frame queue full and in_ready stalling.
    idle_on = 1'b0;
    settle();
    cfg_write(CFG_FRAME_WIDTH, 13'd1);
    cfg_write(CFG_FRAME_HEIGHT, 13'd1);
    cfg_valid <= 1'b0;
    for (int k = 0; k < TAIL_ITEMS; k++) begin
      gen_pair(pix_style_t'($urandom_range(0, 3)), r, d);
      send_pix(r, d, 1'b0, NO_RES);
    end
    in_valid <= 1'b0;

    while (exp_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errs == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- frame_sad_psnr_meter_core.f -----
hw/rtl/fspm_pkg.sv
hw/rtl/fspm_front.sv
hw/rtl/fspm_queue.sv
hw/rtl/fspm_back.sv
hw/rtl/frame_sad_psnr_meter_core.sv
hw/rtl/fspm_checker.sv
dv/frame_sad_psnr_meter_core_tb.sv
